// File: design/bps_pkg.sv
// shared types, codes and helpers for the board power sequencer
package bps_pkg;

  localparam int PH_W       = 5;
  localparam int PH_COUNT   = 23;
  localparam int TICK_W     = 16;
  localparam int WAKE_W     = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_ONKEY_PULSE    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHUTDOWN_DELAY = 1'd1;

  localparam logic [TICK_W-1:0] ONKEY_PULSE_RESET    = 16'd80;
  localparam logic [TICK_W-1:0] SHUTDOWN_DELAY_RESET = 16'd6000;

  localparam logic [WAKE_W-1:0] WAKE_NONE   = 2'd0;
  localparam logic [WAKE_W-1:0] WAKE_BUTTON = 2'd1;
  localparam logic [WAKE_W-1:0] WAKE_RESET  = 2'd2;

  typedef enum logic [PH_COUNT-1:0] {
    PH_START      = 23'(1) << 0,
    PH_INIT       = 23'(1) << 1,
    PH_LOAD       = 23'(1) << 2,
    PH_OFF_A      = 23'(1) << 3,
    PH_OFF_B      = 23'(1) << 4,
    PH_OFF_C      = 23'(1) << 5,
    PH_OFF        = 23'(1) << 6,
    PH_ON_A       = 23'(1) << 7,
    PH_PWR_EN     = 23'(1) << 8,
    PH_ONKEY_LOW  = 23'(1) << 9,
    PH_ONKEY_WAIT = 23'(1) << 10,
    PH_PMIC       = 23'(1) << 11,
    PH_PG_WAIT    = 23'(1) << 12,
    PH_RST_REL    = 23'(1) << 13,
    PH_ON_B       = 23'(1) << 14,
    PH_LED        = 23'(1) << 15,
    PH_UPTIME     = 23'(1) << 16,
    PH_ARM        = 23'(1) << 17,
    PH_ON         = 23'(1) << 18,
    PH_SET_DELAY  = 23'(1) << 19,
    PH_WAIT_DELAY = 23'(1) << 20,
    PH_POWER_DOWN = 23'(1) << 21,
    PH_RESTORE    = 23'(1) << 22
  } phase_t;

  typedef struct packed {
    logic button_press;
    logic shutdown_request;
    logic power_good;
    logic sw_reset_flag;
    logic por_flag;
    logic pin_reset_flag;
  } tick_t;

  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic              power_enable_bar;
    logic              cpu_onkey_bar;
    logic              pmic_request;
    logic              cpu_reset_bar;
    logic              power_led;
    logic              uptime_enable;
    logic [WAKE_W-1:0] wake_source;
    logic              clear_reset_flags;
    logic              restore_outputs;
    logic              interrupts_off;
    logic              save_uptime;
  } result_t;

  // one-hot phase to its index
  function automatic logic [PH_W-1:0] ph_index(phase_t p);
    logic [PH_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < PH_COUNT; i++) begin
      if (p[i]) idx = idx | PH_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: design/bps_if.sv
// request channels of the board power sequencer
interface bps_tick_if;
  logic           valid;
  logic           ready;
  bps_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bps_result_if;
  logic             valid;
  logic             ready;
  bps_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bps_pkg::CFG_ADDR_W-1:0]    addr;
  logic [bps_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// File: design/bps_cfg.sv
// configuration registers: on-key pulse length and shutdown delay
module bps_cfg (
  input  logic                         clk,
  input  logic                         rst,
  bps_cfg_if.sink                      cfg,
  output logic [bps_pkg::TICK_W-1:0]   onkey_ticks,
  output logic [bps_pkg::TICK_W-1:0]   shutdown_ticks
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      onkey_ticks    <= bps_pkg::ONKEY_PULSE_RESET;
      shutdown_ticks <= bps_pkg::SHUTDOWN_DELAY_RESET;
    end else if (cfg.valid) begin
      if (cfg.addr == bps_pkg::CFG_ONKEY_PULSE) begin
        onkey_ticks <= cfg.wdata;
      end else if (cfg.addr == bps_pkg::CFG_SHUTDOWN_DELAY) begin
        shutdown_ticks <= cfg.wdata;
      end
    end
  end

endmodule

// File: design/bps_in_stage.sv
// input register for tick requests
module bps_in_stage (
  input  logic            clk,
  input  logic            rst,
  bps_tick_if.sink        tick,
  input  logic            take,
  output logic            held_valid,
  output bps_pkg::tick_t  held
);

  assign tick.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (tick.ready) begin
      held_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      held <= tick.data;
    end
  end

endmodule

// File: design/bps_core.sv
// sequencer state, next-step logic and result register
module bps_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         held_valid,
  input  bps_pkg::tick_t               held,
  output logic                         take,
  input  logic [bps_pkg::TICK_W-1:0]   onkey_ticks,
  input  logic [bps_pkg::TICK_W-1:0]   shutdown_ticks,
  bps_result_if.source                 result
);

  bps_pkg::phase_t                   phase, phase_next;
  logic [bps_pkg::TICK_W-1:0]        countdown, countdown_next;
  logic                              skip_wait, skip_wait_next;
  logic                              button_latch, button_latch_next;
  logic                              shutdown_latch, shutdown_latch_next;
  logic                              pwr_en_bar, pwr_en_bar_next;
  logic                              onkey_bar, onkey_bar_next;
  logic                              pmic_req, pmic_req_next;
  logic                              rst_bar, rst_bar_next;
  logic                              led, led_next;
  logic                              uptime, uptime_next;
  logic [bps_pkg::WAKE_W-1:0]        wake, wake_next;
  logic                              clr, restore;

  assign take = held_valid && (!result.valid || result.ready);

  always_comb begin
    phase_next          = phase;
    countdown_next      = countdown;
    skip_wait_next      = skip_wait;
    button_latch_next   = button_latch | held.button_press;
    shutdown_latch_next = shutdown_latch | held.shutdown_request;
    pwr_en_bar_next     = pwr_en_bar;
    onkey_bar_next      = onkey_bar;
    pmic_req_next       = pmic_req;
    rst_bar_next        = rst_bar;
    led_next            = led;
    uptime_next         = uptime;
    wake_next           = wake;
    clr                 = 1'b0;
    restore             = 1'b0;
    case (phase)
      bps_pkg::PH_START: phase_next = bps_pkg::PH_INIT;
      bps_pkg::PH_INIT: begin
        // software reset wins, then power-on, then reset pin
        if (held.sw_reset_flag || (!held.por_flag && held.pin_reset_flag)) begin
          skip_wait_next = 1'b1;
        end
        clr        = 1'b1;
        phase_next = bps_pkg::PH_LOAD;
      end
      bps_pkg::PH_LOAD:  phase_next = bps_pkg::PH_OFF_A;
      bps_pkg::PH_OFF_A: phase_next = bps_pkg::PH_OFF_B;
      bps_pkg::PH_OFF_B: phase_next = bps_pkg::PH_OFF_C;
      bps_pkg::PH_OFF_C: begin
        button_latch_next = 1'b0;
        wake_next         = bps_pkg::WAKE_NONE;
        led_next          = 1'b0;
        uptime_next       = 1'b0;
        phase_next        = bps_pkg::PH_OFF;
      end
      bps_pkg::PH_OFF: begin
        if (skip_wait) begin
          skip_wait_next = 1'b0;
          wake_next      = bps_pkg::WAKE_RESET;
          phase_next     = bps_pkg::PH_ON_A;
        end else if (button_latch_next) begin
          button_latch_next = 1'b0;
          wake_next         = bps_pkg::WAKE_BUTTON;
          phase_next        = bps_pkg::PH_ON_A;
        end
      end
      bps_pkg::PH_ON_A: phase_next = bps_pkg::PH_PWR_EN;
      bps_pkg::PH_PWR_EN: begin
        pwr_en_bar_next = 1'b1;
        onkey_bar_next  = 1'b1;
        phase_next      = bps_pkg::PH_ONKEY_LOW;
      end
      bps_pkg::PH_ONKEY_LOW: begin
        onkey_bar_next = 1'b0;
        countdown_next = onkey_ticks;
        phase_next     = bps_pkg::PH_ONKEY_WAIT;
      end
      bps_pkg::PH_ONKEY_WAIT: begin
        if (countdown == '0) begin
          onkey_bar_next = 1'b1;
          phase_next     = bps_pkg::PH_PMIC;
        end else begin
          countdown_next = countdown - 1'b1;
        end
      end
      bps_pkg::PH_PMIC: begin
        pmic_req_next = 1'b1;
        phase_next    = bps_pkg::PH_PG_WAIT;
      end
      bps_pkg::PH_PG_WAIT: begin
        if (held.power_good) phase_next = bps_pkg::PH_RST_REL;
      end
      bps_pkg::PH_RST_REL: begin
        rst_bar_next = 1'b1;
        phase_next   = bps_pkg::PH_ON_B;
      end
      bps_pkg::PH_ON_B: phase_next = bps_pkg::PH_LED;
      bps_pkg::PH_LED: begin
        led_next   = 1'b1;
        phase_next = bps_pkg::PH_UPTIME;
      end
      bps_pkg::PH_UPTIME: begin
        uptime_next = 1'b1;
        phase_next  = bps_pkg::PH_ARM;
      end
      bps_pkg::PH_ARM: begin
        // drop any shutdown request seen during power-on
        shutdown_latch_next = 1'b0;
        phase_next          = bps_pkg::PH_ON;
      end
      bps_pkg::PH_ON: begin
        if (shutdown_latch_next) begin
          shutdown_latch_next = 1'b0;
          phase_next          = bps_pkg::PH_SET_DELAY;
        end
      end
      bps_pkg::PH_SET_DELAY: begin
        countdown_next = shutdown_ticks;
        phase_next     = bps_pkg::PH_WAIT_DELAY;
      end
      bps_pkg::PH_WAIT_DELAY: begin
        if (countdown == '0) begin
          phase_next = bps_pkg::PH_POWER_DOWN;
        end else begin
          countdown_next = countdown - 1'b1;
        end
      end
      bps_pkg::PH_POWER_DOWN: phase_next = bps_pkg::PH_RESTORE;
      bps_pkg::PH_RESTORE: begin
        pwr_en_bar_next = 1'b0;
        onkey_bar_next  = 1'b0;
        pmic_req_next   = 1'b0;
        rst_bar_next    = 1'b0;
        uptime_next     = 1'b0;
        restore         = 1'b1;
        phase_next      = bps_pkg::PH_OFF_A;
      end
      default: phase_next = phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= bps_pkg::PH_START;
      countdown      <= '0;
      skip_wait      <= 1'b0;
      button_latch   <= 1'b0;
      shutdown_latch <= 1'b0;
      pwr_en_bar     <= 1'b0;
      onkey_bar      <= 1'b0;
      pmic_req       <= 1'b0;
      rst_bar        <= 1'b0;
      led            <= 1'b0;
      uptime         <= 1'b0;
      wake           <= bps_pkg::WAKE_NONE;
    end else if (take) begin
      phase          <= phase_next;
      countdown      <= countdown_next;
      skip_wait      <= skip_wait_next;
      button_latch   <= button_latch_next;
      shutdown_latch <= shutdown_latch_next;
      pwr_en_bar     <= pwr_en_bar_next;
      onkey_bar      <= onkey_bar_next;
      pmic_req       <= pmic_req_next;
      rst_bar        <= rst_bar_next;
      led            <= led_next;
      uptime         <= uptime_next;
      wake           <= wake_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.data.phase             <= bps_pkg::ph_index(phase_next);
      result.data.power_enable_bar  <= pwr_en_bar_next;
      result.data.cpu_onkey_bar     <= onkey_bar_next;
      result.data.pmic_request      <= pmic_req_next;
      result.data.cpu_reset_bar     <= rst_bar_next;
      result.data.power_led         <= led_next;
      result.data.uptime_enable     <= uptime_next;
      result.data.wake_source       <= wake_next;
      result.data.clear_reset_flags <= clr;
      result.data.restore_outputs   <= restore;
      result.data.interrupts_off    <= restore;
      result.data.save_uptime       <= restore;
    end
  end

endmodule

// File: design/board_power_sequencer_top.sv
// Board power sequencer, one tick request in and one result out per cycle while results
// are taken. Each tick request is taken into an input register, then a single sequencer
// step (event latching, boot-cause check, timed on-key pulse, power-good wait, timed
// shutdown, output restore) runs from that register into the result register, and a new
// tick can be accepted every cycle while results are taken. A stalled result lets one
// more tick into the input register and then holds the tick channel off until the result
// is taken. The sustained rate is set by the sequencer state update. Configuration
// writes complete in the cycle they are offered.
module board_power_sequencer_top (
  input  logic           clk,
  input  logic           rst,
  bps_tick_if.sink       tick,
  bps_result_if.source   result,
  bps_cfg_if.sink        cfg
);

  logic                         held_valid;
  bps_pkg::tick_t               held;
  logic                         take;
  logic [bps_pkg::TICK_W-1:0]   onkey_ticks;
  logic [bps_pkg::TICK_W-1:0]   shutdown_ticks;

  bps_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .onkey_ticks    (onkey_ticks),
    .shutdown_ticks (shutdown_ticks)
  );

  bps_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  bps_core u_core (
    .clk            (clk),
    .rst            (rst),
    .held_valid     (held_valid),
    .held           (held),
    .take           (take),
    .onkey_ticks    (onkey_ticks),
    .shutdown_ticks (shutdown_ticks),
    .result         (result)
  );

endmodule

// File: design/bps_checker.sv
// port-level checks for the board power sequencer and their bind
module bps_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  logic             res_ready,
  input  bps_pkg::result_t res_data
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // restore step lands in the off flow with every pin but the power led released
  a_restore: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.restore_outputs |->
      res_data.phase == 5'd3 && !res_data.power_enable_bar && !res_data.cpu_onkey_bar &&
      !res_data.pmic_request && !res_data.cpu_reset_bar && !res_data.uptime_enable)
    else $error("restore pulse with wrong state");

  a_clear_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.clear_reset_flags |-> res_data.phase == 5'd2 &&
      !res_data.restore_outputs)
    else $error("clear flags outside boot-cause check");

  a_uptime_led: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.uptime_enable |-> res_data.power_led)
    else $error("uptime counting without power led");

endmodule

bind board_power_sequencer_top bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
